// ----- rtl/rbab_pkg.sv -----
// shared constants, codes, types and address helper for the rectangle blitter
package rbab_pkg;

	localparam int IMAGE_WIDTH     = 256;
	localparam int IMAGE_HEIGHT    = 256;
	localparam int BYTES_PER_PIXEL = 4;
	localparam int MEM_BYTES       = IMAGE_WIDTH * IMAGE_HEIGHT * BYTES_PER_PIXEL;
	// memory size is a power of two, so wrapping is a truncation
	localparam int ADDR_W          = $clog2(MEM_BYTES);
	localparam int CHAN_W          = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

	localparam int IN_ADDR_W = 18;
	localparam int BYTE_W    = 8;
	localparam int COORD_W   = 8;
	localparam int EXTENT_W  = 9;
	localparam int POS_W     = 10;
	localparam int ACC_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [BYTE_W-1:0] ALPHA_MAX = 8'd255;

	localparam logic [1:0] ACT_WR_SRC = 2'd0;
	localparam logic [1:0] ACT_WR_DST = 2'd1;
	localparam logic [1:0] ACT_START  = 2'd2;
	localparam logic [1:0] ACT_RD_DST = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_X        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_Y        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_X        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_Y        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MAC1,
		S_MAC2,
		S_RDOUT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] op_a;
		logic [BYTE_W-1:0] op_b;
		logic [ACC_W-1:0]  acc;
	} mac_req_t;

	// (row * width + column) * bytes per pixel + channel, wrapped to the memory
	function automatic logic [ADDR_W-1:0] pixel_addr(input logic [POS_W-1:0] row,
			input logic [POS_W-1:0] col, input logic [CHAN_W-1:0] chan);
		logic [31:0] a;
		a = (32'(row) * 32'(IMAGE_WIDTH) + 32'(col)) * 32'(BYTES_PER_PIXEL) + 32'(chan);
		return a[ADDR_W-1:0];
	endfunction

endpackage

// ----- rtl/rbab_ram.sv -----
// generic single write, single read ram with registered read data
module rbab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/rbab_mac.sv -----
// shared multiply-accumulate unit used for both blend products
module rbab_mac (
	input  rbab_pkg::mac_req_t               req,
	output logic [rbab_pkg::ACC_W-1:0]       sum
);
	import rbab_pkg::*;

	logic [2*BYTE_W-1:0] prod;

	assign prod = req.op_a * req.op_b;
	assign sum  = req.acc + ACC_W'(prod);

endmodule

// ----- rtl/rect_blit_alpha_blend.sv -----
// top level: configuration registers, image memories and blit sequencer
// Rectangle blitter with constant-alpha blend over two byte images of
// IMAGE_WIDTH*IMAGE_HEIGHT*BYTES_PER_PIXEL bytes each, held in single-port-read
// rams whose contents are undefined until written (no clearing pass). Every
// input transfer gives exactly one result transfer. A source or destination
// write is taken and its result is registered for the next cycle; a destination
// read passes through the registered ram read before its result is registered.
// A start walks the rectangle one byte at a time: a ram read, then the write
// for a plain copy, with an extra step before the write when blending, since the
// two products go through one shared multiplier; an empty rectangle goes
// straight to the finish. The block takes no new item while a read or start is
// in progress, nor while a result is waiting to be taken.
module rect_blit_alpha_blend (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rbab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbab_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic [rbab_pkg::IN_ADDR_W-1:0]     byte_address,
	input  logic [rbab_pkg::BYTE_W-1:0]        write_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rbab_pkg::BYTE_W-1:0]        read_data,
	output logic                               done_res
);
	import rbab_pkg::*;

	logic [COORD_W-1:0]  src_x_q, src_y_q, dst_x_q, dst_y_q;
	logic [EXTENT_W-1:0] rect_width_q, rect_height_q;
	logic                blend_q;
	logic [BYTE_W-1:0]   alpha_q;

	state_t state_q, state_d;

	logic [EXTENT_W-1:0] row_q, col_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [ACC_W-1:0]    acc_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   read_data_q;
	logic                done_res_q;

	logic in_xfer, out_free, empty_rect;
	logic last_chan, last_col, last_row, last_byte;
	logic advance, start;

	logic [POS_W-1:0]  src_row, src_col, dst_row, dst_col;
	logic [ADDR_W-1:0] src_addr, dst_addr, in_addr;

	logic              src_we, src_re, dst_we, dst_re;
	logic [ADDR_W-1:0] dst_waddr, dst_raddr;
	logic [BYTE_W-1:0] dst_wdata, src_rdata, dst_rdata;

	mac_req_t          mac_req;
	logic [ACC_W-1:0]  mac_sum;

	logic              out_load;
	logic [BYTE_W-1:0] out_read_data;
	logic              out_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q       <= '0;
			src_y_q       <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
			dst_x_q       <= '0;
			dst_y_q       <= '0;
			blend_q       <= 1'b0;
			alpha_q       <= ALPHA_MAX;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SRC_X:        src_x_q       <= cfg_data[COORD_W-1:0];
				REG_SRC_Y:        src_y_q       <= cfg_data[COORD_W-1:0];
				REG_RECT_WIDTH:   rect_width_q  <= cfg_data[EXTENT_W-1:0];
				REG_RECT_HEIGHT:  rect_height_q <= cfg_data[EXTENT_W-1:0];
				REG_DST_X:        dst_x_q       <= cfg_data[COORD_W-1:0];
				REG_DST_Y:        dst_y_q       <= cfg_data[COORD_W-1:0];
				REG_BLEND_ENABLE: blend_q       <= cfg_data[0];
				REG_ALPHA:        alpha_q       <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE) && out_free;
	assign in_xfer    = in_valid && in_ready;
	assign start      = in_xfer && (action == ACT_START);
	assign empty_rect = (rect_width_q == '0) || (rect_height_q == '0);

	assign last_chan = (chan_q == CHAN_W'(BYTES_PER_PIXEL - 1));
	assign last_col  = (col_q == rect_width_q - EXTENT_W'(1));
	assign last_row  = (row_q == rect_height_q - EXTENT_W'(1));
	assign last_byte = last_chan && last_col && last_row;

	// address generation from the walk counters
	assign src_row  = POS_W'(src_y_q) + POS_W'(row_q);
	assign src_col  = POS_W'(src_x_q) + POS_W'(col_q);
	assign dst_row  = POS_W'(dst_y_q) + POS_W'(row_q);
	assign dst_col  = POS_W'(dst_x_q) + POS_W'(col_q);
	assign src_addr = pixel_addr(src_row, src_col, chan_q);
	assign dst_addr = pixel_addr(dst_row, dst_col, chan_q);
	assign in_addr  = byte_address[ADDR_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (action)
						ACT_START:  state_d = empty_rect ? S_FIN : S_RD;
						ACT_RD_DST: state_d = S_RDOUT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_RD:    state_d = S_MAC1;
			S_MAC1: begin
				if (blend_q) begin
					state_d = S_MAC2;
				end else begin
					state_d = last_byte ? S_FIN : S_RD;
				end
			end
			S_MAC2:  state_d = last_byte ? S_FIN : S_RD;
			S_RDOUT: state_d = out_free ? S_IDLE : S_RDOUT;
			S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		src_we        = 1'b0;
		src_re        = 1'b0;
		dst_we        = 1'b0;
		dst_re        = 1'b0;
		dst_waddr     = dst_addr;
		dst_raddr     = dst_addr;
		dst_wdata     = src_rdata;
		advance       = 1'b0;
		out_load      = 1'b0;
		out_read_data = '0;
		out_done      = 1'b0;
		mac_req.op_a  = src_rdata;
		mac_req.op_b  = alpha_q;
		mac_req.acc   = '0;
		unique case (state_q)
			S_IDLE: begin
				dst_waddr = in_addr;
				dst_raddr = in_addr;
				dst_wdata = write_data;
				if (in_xfer) begin
					unique case (action)
						ACT_WR_SRC: begin
							src_we   = 1'b1;
							out_load = 1'b1;
						end
						ACT_WR_DST: begin
							dst_we   = 1'b1;
							out_load = 1'b1;
						end
						ACT_RD_DST: dst_re = 1'b1;
						default: ;
					endcase
				end
			end
			S_RD: begin
				src_re = 1'b1;
				dst_re = 1'b1;
			end
			S_MAC1: begin
				// plain copy writes the source byte here
				if (!blend_q) begin
					dst_we  = 1'b1;
					advance = 1'b1;
				end
			end
			S_MAC2: begin
				mac_req.op_a = dst_rdata;
				mac_req.op_b = ALPHA_MAX - alpha_q;
				mac_req.acc  = acc_q;
				dst_wdata    = mac_sum[ACC_W-1 -: BYTE_W];
				dst_we       = 1'b1;
				advance      = 1'b1;
			end
			S_RDOUT: begin
				out_load      = out_free;
				out_read_data = dst_rdata;
			end
			S_FIN: begin
				out_load = out_free;
				out_done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk counters: channel, then pixel, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (start) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (advance) begin
			if (last_chan) begin
				chan_q <= '0;
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + EXTENT_W'(1);
				end else begin
					col_q <= col_q + EXTENT_W'(1);
				end
			end else begin
				chan_q <= chan_q + CHAN_W'(1);
			end
		end
	end

	// first product held for the second pass through the unit
	always_ff @(posedge clk) begin
		if (state_q == S_MAC1) begin
			acc_q <= mac_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_data_q <= out_read_data;
			done_res_q  <= out_done;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign done_res  = done_res_q;

	rbab_mac u_mac (
		.req (mac_req),
		.sum (mac_sum)
	);

	rbab_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_BYTES)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (in_addr),
		.wdata (write_data),
		.re    (src_re),
		.raddr (src_addr),
		.rdata (src_rdata)
	);

	rbab_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_BYTES)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we),
		.waddr (dst_waddr),
		.wdata (dst_wdata),
		.re    (dst_re),
		.raddr (dst_raddr),
		.rdata (dst_rdata)
	);

	a_read_goes_to_rdout: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && action == ACT_RD_DST) |=> (state_q == S_RDOUT))
		else $error("read transfer did not move to result state");

	a_done_has_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (read_data == '0))
		else $error("start result carries read data");

	a_one_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(src_we && dst_we))
		else $error("both image memories written in one cycle");

	a_blit_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_we && state_q != S_IDLE) |-> (state_q == S_MAC1 || state_q == S_MAC2))
		else $error("destination written outside a blit write step");

endmodule

// ----- bench/rect_blit_alpha_blend_test.sv -----
// self-checking bench for the rectangle blitter: access items, copies and blends
module rect_blit_alpha_blend_test;
	import rbab_pkg::*;

	localparam int STALL_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 700;
	localparam int ADDR_MAX     = (1 << IN_ADDR_W) - 1;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [BYTE_W-1:0] read_data;
		logic              done_res;
	} access_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            action;
	logic [IN_ADDR_W-1:0]  byte_address;
	logic [BYTE_W-1:0]     write_data;
	logic                  out_valid;
	logic                  out_ready;
	logic [BYTE_W-1:0]     read_data;
	logic                  done_res;

	// image contents as the block should hold them
	bit [BYTE_W-1:0] src_pixels [MEM_BYTES];
	bit [BYTE_W-1:0] dst_pixels [MEM_BYTES];
	bit              src_known [MEM_BYTES];
	bit              dst_known [MEM_BYTES];
	int              dst_list [$];

	int m_src_x = 0;
	int m_src_y = 0;
	int m_rect_w = 0;
	int m_rect_h = 0;
	int m_dst_x = 0;
	int m_dst_y = 0;
	int m_blend = 0;
	int m_alpha = 255;

	access_result_t access_results [$];

	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int blits = 0;
	int blended_blits = 0;
	int settings = 0;
	int burst_left = 0;
	bit sender_gaps = 1'b1;
	bit hold_request = 1'b0;
	int stall_cycles = 0;

	rect_blit_alpha_blend uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.byte_address(byte_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.done_res(done_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int byte_addr(int row, int col, int chan);
		return ((row * IMAGE_WIDTH + col) * BYTES_PER_PIXEL + chan) % MEM_BYTES;
	endfunction

	function automatic void store_dst(int a, bit [BYTE_W-1:0] value);
		dst_pixels[a] = value;
		if (!dst_known[a]) begin
			dst_known[a] = 1'b1;
			dst_list.push_back(a);
		end
	endfunction

	// walk order: rows, then pixels, then channels
	function automatic void run_rect();
		int sa;
		int da;
		int mixed;
		for (int i = 0; i < m_rect_h; i++)
			for (int j = 0; j < m_rect_w; j++)
				for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
					sa = byte_addr(m_src_y + i, m_src_x + j, k);
					da = byte_addr(m_dst_y + i, m_dst_x + j, k);
					if (m_blend != 0) begin
						mixed = (int'(src_pixels[sa]) * m_alpha +
							int'(dst_pixels[da]) * (int'(ALPHA_MAX) - m_alpha)) >> 8;
						store_dst(da, mixed[BYTE_W-1:0]);
					end else begin
						store_dst(da, src_pixels[sa]);
					end
				end
	endfunction

	function automatic void apply_access(logic [1:0] act, int addr, int data);
		access_result_t r;
		int a;
		a = addr % MEM_BYTES;
		r.read_data = '0;
		r.done_res = 1'b0;
		case (act)
			ACT_WR_SRC: begin
				src_pixels[a] = data[BYTE_W-1:0];
				src_known[a] = 1'b1;
			end
			ACT_WR_DST: store_dst(a, data[BYTE_W-1:0]);
			ACT_START: begin
				run_rect();
				r.done_res = 1'b1;
				blits++;
				if (m_blend != 0 && m_rect_w != 0 && m_rect_h != 0)
					blended_blits++;
			end
			default: r.read_data = dst_pixels[a];
		endcase
		access_results.push_back(r);
	endfunction

	// sender: bursts of random length with random gaps between them
	task automatic send_item(input logic [1:0] act, input int addr, input int data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		byte_address <= addr[IN_ADDR_W-1:0];
		write_data <= data[BYTE_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_access(act, addr & ADDR_MAX, data & 255);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (access_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_rect(input int sx, input int sy, input int w, input int h,
			input int dx, input int dy, input int blend, input int a);
		write_reg(REG_SRC_X, sx);
		write_reg(REG_SRC_Y, sy);
		write_reg(REG_RECT_WIDTH, w);
		write_reg(REG_RECT_HEIGHT, h);
		write_reg(REG_DST_X, dx);
		write_reg(REG_DST_Y, dy);
		write_reg(REG_BLEND_ENABLE, blend);
		write_reg(REG_ALPHA, a);
		cfg_write <= 1'b0;
		m_src_x = sx;
		m_src_y = sy;
		m_rect_w = w;
		m_rect_h = h;
		m_dst_x = dx;
		m_dst_y = dy;
		m_blend = blend;
		m_alpha = a;
		settings++;
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_item(ACT_WR_SRC, $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
			1: send_item(ACT_WR_DST, $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
			default: send_item(ACT_RD_DST, dst_list[$urandom_range(0, dst_list.size() - 1)],
				$urandom_range(0, 255));
		endcase
	endtask

	// make sure every byte the blit will read has been written
	task automatic fill_rect(input bit dest, input bit rewrite_all);
		int a;
		bit known;
		for (int i = 0; i < m_rect_h; i++)
			for (int j = 0; j < m_rect_w; j++)
				for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
					if (dest) begin
						a = byte_addr(m_dst_y + i, m_dst_x + j, k);
						known = dst_known[a];
					end else begin
						a = byte_addr(m_src_y + i, m_src_x + j, k);
						known = src_known[a];
					end
					if (!known || rewrite_all || $urandom_range(0, 7) == 0)
						send_item(dest ? ACT_WR_DST : ACT_WR_SRC, a, $urandom_range(0, 255));
					if (!rewrite_all && $urandom_range(0, 11) == 0)
						send_noise();
				end
	endtask

	task automatic read_rect_samples(input int n);
		if (m_rect_w != 0 && m_rect_h != 0)
			repeat (n)
				send_item(ACT_RD_DST, byte_addr(m_dst_y + $urandom_range(0, m_rect_h - 1),
					m_dst_x + $urandom_range(0, m_rect_w - 1),
					$urandom_range(0, BYTES_PER_PIXEL - 1)), $urandom_range(0, 255));
	endtask

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom_range(250, 255);
		if (r == 3)
			return 0;
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_extent(int biggest);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r <= 15)
			return $urandom_range(1, 3);
		return $urandom_range(4, biggest);
	endfunction

	task automatic test_access_extremes();
		// start on the reset settings: empty rectangle
		send_item(ACT_START, 0, 0);
		send_item(ACT_WR_SRC, MEM_BYTES - 1, 8'hff);
		send_item(ACT_WR_SRC, MEM_BYTES - 2, 8'h00);
		send_item(ACT_WR_SRC, MEM_BYTES - 3, 8'ha5);
		send_item(ACT_WR_SRC, MEM_BYTES - 4, 8'h5a);
		send_item(ACT_WR_SRC, 0, 8'h01);
		send_item(ACT_WR_SRC, 1, 8'h80);
		send_item(ACT_WR_SRC, 2, 8'h7f);
		send_item(ACT_WR_SRC, 3, 8'hfe);
		send_item(ACT_WR_DST, MEM_BYTES - 1, 8'h00);
		send_item(ACT_WR_DST, MEM_BYTES / 2, 8'hc3);
		send_item(ACT_RD_DST, MEM_BYTES - 1, 8'hff);
		send_item(ACT_RD_DST, MEM_BYTES / 2, 0);
	endtask

	// two pixels from the last pixel of the image: the second runs past the
	// right edge and wraps round to address zero
	task automatic test_edge_wrap_blits();
		wait_drained();
		set_rect(255, 255, 2, 1, 255, 255, 0, 255);
		send_item(ACT_START, ADDR_MAX, 8'hff);
		send_item(ACT_RD_DST, 0, 0);
		send_item(ACT_RD_DST, MEM_BYTES - 1, 0);
		wait_drained();
		set_rect(255, 255, 2, 1, 255, 255, 1, 0);
		send_item(ACT_START, 0, 0);
		send_item(ACT_RD_DST, MEM_BYTES - 4, 0);
		wait_drained();
		set_rect(255, 255, 2, 1, 255, 255, 1, 255);
		send_item(ACT_START, 0, 0);
		send_item(ACT_RD_DST, 3, 0);
	endtask

	task automatic test_empty_rectangles();
		wait_drained();
		set_rect(255, 255, 256, 0, 255, 255, 1, 128);
		send_item(ACT_START, 0, 0);
		wait_drained();
		set_rect(0, 0, 0, 256, 0, 0, 0, 0);
		send_item(ACT_START, 0, 0);
	endtask

	task automatic test_full_width_row();
		wait_drained();
		set_rect(0, $urandom_range(0, 255), 256, 1, 128, pick_coord(), 0, 255);
		fill_rect(1'b0, 1'b1);
		send_item(ACT_START, $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
		read_rect_samples(24);
	endtask

	task automatic test_output_stall();
		wait_drained();
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (60) send_noise();
		send_item(ACT_START, 0, 0);
		read_rect_samples(4);
		// sender waits for every result before going on
		wait_drained();
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			wait_drained();
			sender_gaps = ($urandom_range(0, 3) != 0);
			set_rect(pick_coord(), pick_coord(), pick_extent(6), pick_extent(4),
				pick_coord(), pick_coord(), $urandom_range(0, 1),
				($urandom_range(0, 4) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255));
			repeat ($urandom_range(1, 3)) begin
				fill_rect(1'b0, 1'b0);
				if (m_blend != 0)
					fill_rect(1'b1, 1'b0);
				// the destination is only known beforehand when it was filled for a blend
				if (m_blend != 0 && $urandom_range(0, 9) == 0)
					read_rect_samples(1);
				send_item(ACT_START, $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
				// a second start without fresh data repeats the blit over its own result
				if ($urandom_range(0, 7) == 0)
					send_item(ACT_START, $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
				read_rect_samples($urandom_range(1, 4));
				if ($urandom_range(0, 3) == 0)
					send_noise();
			end
		end
		sender_gaps = 1'b1;
	endtask

	// receiver: stall pattern changes at random, with long hold-offs on request
	initial begin : receiver
		int mode;
		int cycle;
		int hold_left;
		mode = 0;
		cycle = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			cycle++;
			if (cycle % 256 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ((cycle % 7) >= 2);
					default: out_ready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		access_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (access_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding: read_data %02h done_res %0b",
					$time, read_data, done_res);
			end else begin
				want = access_results.pop_front();
				results_checked++;
				if (read_data !== want.read_data) begin
					errors++;
					$display("%0t: read_data expected %02h got %02h", $time, want.read_data,
						read_data);
				end
				if (done_res !== want.done_res) begin
					errors++;
					$display("%0t: done_res expected %0b got %0b", $time, want.done_res,
						done_res);
				end
			end
		end
	end

	// no transfer on either side for too long means the block has hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				stall_cycles, access_results.size());
			$display("rect_blit_alpha_blend_test NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_SRC_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_WR_SRC;
		byte_address <= '0;
		write_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_access_extremes();
		test_edge_wrap_blits();
		test_empty_rectangles();
		test_full_width_row();
		test_output_stall();
		test_random_traffic();

		wait_drained();
		repeat (16) @(posedge clk);
		if (access_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, access_results.size());
		end
		$display("covered %0d items and %0d results: %0d starts (%0d blended), %0d settings",
			items_sent, results_checked, blits, blended_blits, settings);
		$display("including a full-width row, empty rectangles, edge wrap and output stalls");
		if (errors == 0)
			$display("rect_blit_alpha_blend_test OK");
		else
			$display("rect_blit_alpha_blend_test NOT OK");
		$finish;
	end

endmodule
